[sv/tlsdf_pkg.sv]
// ----------------------------------------------------------------------------
// tlsdf_pkg
// shared types and constants of the record deframer
// ----------------------------------------------------------------------------
package tlsdf_pkg;

    localparam logic [7:0]  LEGACY_MAJOR       = 8'h03;
    localparam logic [7:0]  TYPE_CCS           = 8'd20;
    localparam logic [7:0]  TYPE_APP_DATA      = 8'd23;
    localparam logic [15:0] PLAINTEXT_LIMIT_RST  = 16'd16384;
    localparam logic [15:0] CIPHERTEXT_LIMIT_RST = 16'd16640;
    localparam logic [2:0]  HDR_LAST_BYTE      = 3'd4;

    typedef enum logic [1:0] {
        REG_PLAINTEXT_LIMIT  = 2'd0,
        REG_CIPHERTEXT_LIMIT = 2'd1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        KIND_HEADER  = 2'd0,
        KIND_PAYLOAD = 2'd1,
        KIND_ERROR   = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ERR_NONE     = 3'd0,
        ERR_VERSION  = 3'd1,
        ERR_TYPE     = 3'd2,
        ERR_EMPTY    = 3'd3,
        ERR_OVERFLOW = 3'd4
    } err_t;

    typedef struct packed {
        logic [7:0]  content_type;
        logic [7:0]  version_major;
        logic [15:0] record_length;
        logic [15:0] plaintext_limit;
        logic [15:0] ciphertext_limit;
    } hdr_t;

endpackage

[sv/tls13_record_deframer.sv]
// ----------------------------------------------------------------------------
// tls13_record_deframer
// byte-wide record deframer: header gather, checks, payload pass-through
// ----------------------------------------------------------------------------
// a result is registered and appears in the cycle after the byte that causes it
// throughput: one byte per cycle, limited only by the output register draining
// a byte is taken whenever the output register is empty or being read
// reset clears the parse state, the sticky error and restores the default limits
// ----------------------------------------------------------------------------
module tls13_record_deframer
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  in_byte,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  kind,
    output logic [7:0]  data_byte,
    output logic [7:0]  content_type,
    output logic [15:0] record_length,
    output logic        last_of_record,
    output logic [2:0]  error_code,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    logic [15:0] plaintext_limit_reg;
    logic [15:0] ciphertext_limit_reg;

    logic [2:0]  header_count_reg, header_count_next;
    logic [7:0]  type_reg, type_next;
    logic [7:0]  major_reg, major_next;
    logic [15:0] length_reg, length_next;
    logic [15:0] payload_left_reg, payload_left_next;
    logic        failed_reg, failed_next;

    logic               out_valid_reg, out_valid_next;
    tlsdf_pkg::kind_t   kind_reg, kind_next;
    logic [7:0]         data_reg, data_next;
    logic [7:0]         rtype_reg, rtype_next;
    logic [15:0]        rlen_reg, rlen_next;
    logic               last_reg, last_next;
    tlsdf_pkg::err_t    err_reg, err_next;

    logic               in_accept;
    logic               result_load;
    tlsdf_pkg::hdr_t    hdr;
    tlsdf_pkg::err_t    hdr_err;

    assign cfg_ready = 1'b1;
    assign in_stall  = out_valid_reg & out_stall;
    assign in_accept = in_valid & ~in_stall;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plaintext_limit_reg  <= tlsdf_pkg::PLAINTEXT_LIMIT_RST;
            ciphertext_limit_reg <= tlsdf_pkg::CIPHERTEXT_LIMIT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                tlsdf_pkg::REG_PLAINTEXT_LIMIT:  plaintext_limit_reg  <= cfg_data;
                tlsdf_pkg::REG_CIPHERTEXT_LIMIT: ciphertext_limit_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign hdr.content_type     = type_reg;
    assign hdr.version_major    = major_reg;
    assign hdr.record_length    = {length_reg[15:8], in_byte};
    assign hdr.plaintext_limit  = plaintext_limit_reg;
    assign hdr.ciphertext_limit = ciphertext_limit_reg;

    tlsdf_hdr_check u_hdr_check
    (
        .hdr (hdr),
        .err (hdr_err)
    );

    always_comb
    begin
        header_count_next = header_count_reg;
        type_next         = type_reg;
        major_next        = major_reg;
        length_next       = length_reg;
        payload_left_next = payload_left_reg;
        failed_next       = failed_reg;
        result_load       = 1'b0;
        kind_next         = kind_reg;
        data_next         = data_reg;
        rtype_next        = rtype_reg;
        rlen_next         = rlen_reg;
        last_next         = last_reg;
        err_next          = err_reg;

        if (in_accept && !failed_reg)
        begin
            if (payload_left_reg != 16'd0)
            begin
                result_load       = 1'b1;
                kind_next         = tlsdf_pkg::KIND_PAYLOAD;
                data_next         = in_byte;
                rtype_next        = type_reg;
                rlen_next         = length_reg;
                last_next         = (payload_left_reg == 16'd1);
                err_next          = tlsdf_pkg::ERR_NONE;
                payload_left_next = payload_left_reg - 16'd1;
            end
            else if (header_count_reg == tlsdf_pkg::HDR_LAST_BYTE)
            begin
                result_load       = 1'b1;
                header_count_next = 3'd0;
                length_next       = hdr.record_length;
                data_next         = 8'd0;
                rtype_next        = type_reg;
                rlen_next         = hdr.record_length;
                last_next         = 1'b0;
                err_next          = hdr_err;
                if (hdr_err != tlsdf_pkg::ERR_NONE)
                begin
                    failed_next = 1'b1;
                    kind_next   = tlsdf_pkg::KIND_ERROR;
                end
                else
                begin
                    kind_next         = tlsdf_pkg::KIND_HEADER;
                    payload_left_next = hdr.record_length;
                end
            end
            else
            begin
                header_count_next = header_count_reg + 3'd1;
                case (header_count_reg)
                    3'd0:    type_next   = in_byte;
                    3'd1:    major_next  = in_byte;
                    3'd3:    length_next = {in_byte, 8'd0};
                    default: ;
                endcase
            end
        end

        if (result_load)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg & out_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_count_reg <= 3'd0;
            type_reg         <= 8'd0;
            major_reg        <= 8'd0;
            length_reg       <= 16'd0;
            payload_left_reg <= 16'd0;
            failed_reg       <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            header_count_reg <= header_count_next;
            type_reg         <= type_next;
            major_reg        <= major_next;
            length_reg       <= length_next;
            payload_left_reg <= payload_left_next;
            failed_reg       <= failed_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg  <= kind_next;
        data_reg  <= data_next;
        rtype_reg <= rtype_next;
        rlen_reg  <= rlen_next;
        last_reg  <= last_next;
        err_reg   <= err_next;
    end

    assign out_valid      = out_valid_reg;
    assign kind           = kind_reg;
    assign data_byte      = data_reg;
    assign content_type   = rtype_reg;
    assign record_length  = rlen_reg;
    assign last_of_record = last_reg;
    assign error_code     = err_reg;

    // error is sticky until reset
    assert property (@(posedge clk) disable iff (!rst_n)
        failed_reg |=> failed_reg)
        else $error("sticky error flag cleared");

    // no result once failed
    assert property (@(posedge clk) disable iff (!rst_n)
        failed_reg |-> !result_load)
        else $error("result produced after error");

    // header gathering and payload phase never overlap
    assert property (@(posedge clk) disable iff (!rst_n)
        (payload_left_reg != 16'd0) |-> (header_count_reg == 3'd0))
        else $error("header count nonzero during payload");

    // an error transaction always sets the sticky flag
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_load && kind_next == tlsdf_pkg::KIND_ERROR) |=> failed_reg)
        else $error("error emitted without sticky flag");

    // header count stays within the five header bytes
    assert property (@(posedge clk) disable iff (!rst_n)
        header_count_reg <= tlsdf_pkg::HDR_LAST_BYTE)
        else $error("header count out of range");

endmodule

[sv/tlsdf_hdr_check.sv]
// ----------------------------------------------------------------------------
// tlsdf_hdr_check
// ordered validity checks on a completed record header
// ----------------------------------------------------------------------------
module tlsdf_hdr_check
(
    input  tlsdf_pkg::hdr_t hdr,
    output tlsdf_pkg::err_t err
);

    logic type_ok;
    logic over_limit;

    assign type_ok = (hdr.content_type >= tlsdf_pkg::TYPE_CCS)
                  && (hdr.content_type <= tlsdf_pkg::TYPE_APP_DATA);

    assign over_limit = (hdr.content_type == tlsdf_pkg::TYPE_APP_DATA)
                      ? (hdr.record_length > hdr.ciphertext_limit)
                      : (hdr.record_length > hdr.plaintext_limit);

    always_comb
    begin
        if (hdr.version_major != tlsdf_pkg::LEGACY_MAJOR)
        begin
            err = tlsdf_pkg::ERR_VERSION;
        end
        else if (!type_ok)
        begin
            err = tlsdf_pkg::ERR_TYPE;
        end
        else if (hdr.record_length == 16'd0)
        begin
            err = tlsdf_pkg::ERR_EMPTY;
        end
        else if (over_limit)
        begin
            err = tlsdf_pkg::ERR_OVERFLOW;
        end
        else
        begin
            err = tlsdf_pkg::ERR_NONE;
        end
    end

endmodule
